// File: design/fud_pkg.sv
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types and constants for the form-encoded string decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_EOP   = 2'd2;

  // Special characters of the encoding
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CH_EQUALS  = 8'h3D;  // '='
  localparam logic [7:0] CH_SPACE   = 8'h20;  // decoded '+'
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  // Escape progress codes
  localparam logic [1:0] ESC_IDLE  = 2'd0;
  localparam logic [1:0] ESC_FIRST = 2'd1;  // after '%'
  localparam logic [1:0] ESC_SECOND = 2'd2; // after one escape character

  // Result queue depth (at most two results per input word)
  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } fud_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       has_value;
    logic       end_of_data;
    logic       run_last;
  } fud_out_t;

  // Decoded data byte: lowercase in the name part only
  function automatic fud_out_t fud_data(input logic value_part, input logic [7:0] b);
    fud_out_t r;
    r = '0;
    r.kind = value_part ? KIND_VALUE : KIND_NAME;
    if (!value_part && b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r.out_byte = b + CASE_DELTA;
    end else begin
      r.out_byte = b;
    end
    return r;
  endfunction

  // End-of-pair marker
  function automatic fud_out_t fud_marker(input logic hv, input logic eod);
    fud_out_t r;
    r = '0;
    r.kind        = KIND_EOP;
    r.has_value   = hv;
    r.end_of_data = eod;
    return r;
  endfunction

endpackage

// File: design/form_urlencoded_decoder_unit.sv
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_unit
// Streaming decoder for form-encoded byte strings, one raw byte per word.
// ----------------------------------------------------------------------------
// Takes one raw byte per clock and returns zero, one or two decoded results
// for it, in order, through a four-entry result queue: name bytes (lowercased),
// value bytes, and end-of-pair markers. The input accepts a byte in every cycle
// while the queue has room for two more results; a long run of bytes that each
// yield two results outpaces the single output port of the result queue, so
// the input then has to wait. A stalled output side fills the queue and then
// holds the input off.
module form_urlencoded_decoder_unit
  import fud_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  fud_in_t  in_data,
  output logic     out_valid,
  input  logic     out_rdy,
  output fud_out_t out_data
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  // Decoder state
  logic       vp_r, vp_nxt;
  logic [1:0] esc_cnt_r, esc_cnt_nxt;
  logic [3:0] esc_high_r, esc_high_nxt;
  logic       esc_ok_r, esc_ok_nxt;
  logic       esc_abort_r, esc_abort_nxt;

  // Result queue
  fud_out_t   fifo_r [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic       in_fire, out_fire;
  fud_out_t   res0, res1;
  logic [1:0] res_cnt;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_rdy;
  assign in_ready = (count_r <= CNT_W'(RES_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_data  = fifo_r[rd_ptr_r];

  // Decode one byte against the current state
  always_comb begin
    logic [7:0] b;
    logic       last;
    logic       delim;
    logic       handled;
    logic       done;
    logic       d_ok;
    logic [3:0] d_val;
    logic [7:0] v;
    fud_out_t   res [2];
    logic [1:0] cnt;

    b       = in_data.in_byte;
    last    = in_data.in_last;
    handled = 1'b0;
    done    = 1'b0;
    cnt     = 2'd0;
    res[0]  = '0;
    res[1]  = '0;
    v       = '0;

    vp_nxt        = vp_r;
    esc_cnt_nxt   = esc_cnt_r;
    esc_high_nxt  = esc_high_r;
    esc_ok_nxt    = esc_ok_r;
    esc_abort_nxt = esc_abort_r;

    // Classify the byte as a hex digit
    d_ok  = 1'b1;
    d_val = '0;
    if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) begin
      d_val = 4'(b - CH_DIGIT_0);
    end else if (b >= CH_UPPER_A && b <= CH_UPPER_F) begin
      d_val = 4'(b - CH_UPPER_A + 8'd10);
    end else if (b >= CH_LOWER_A && b <= CH_LOWER_F) begin
      d_val = 4'(b - CH_LOWER_A + 8'd10);
    end else begin
      d_ok = 1'b0;
    end

    delim = (b == CH_AMP) || (b == CH_EQUALS && !vp_r);

    // Advance or flush an escape in progress
    if (esc_cnt_r != ESC_IDLE) begin
      if (!delim) begin
        handled = 1'b1;
        if (esc_cnt_r == ESC_FIRST) begin
          if (d_ok) begin
            esc_high_nxt = d_val;
            esc_ok_nxt   = 1'b1;
          end else begin
            esc_abort_nxt = 1'b1;
          end
          esc_cnt_nxt = ESC_SECOND;
        end else begin
          if (esc_ok_r && !esc_abort_r) begin
            v = d_ok ? {esc_high_r, d_val} : {4'h0, esc_high_r};
          end
          res[cnt[0]] = fud_data(vp_r, v);
          cnt = cnt + 2'd1;
          esc_cnt_nxt   = ESC_IDLE;
          esc_high_nxt  = '0;
          esc_ok_nxt    = 1'b0;
          esc_abort_nxt = 1'b0;
        end
      end else begin
        if (esc_cnt_r == ESC_SECOND && esc_ok_r && !esc_abort_r) begin
          v = {4'h0, esc_high_r};
        end
        res[cnt[0]] = fud_data(vp_r, v);
        cnt = cnt + 2'd1;
        esc_cnt_nxt   = ESC_IDLE;
        esc_high_nxt  = '0;
        esc_ok_nxt    = 1'b0;
        esc_abort_nxt = 1'b0;
      end
    end

    // Plain byte handling
    if (!handled) begin
      if (b == CH_AMP) begin
        res[cnt[0]] = fud_marker(vp_r, last);
        cnt = cnt + 2'd1;
        vp_nxt = 1'b0;
        done   = 1'b1;
      end else if (b == CH_EQUALS && !vp_r) begin
        vp_nxt = 1'b1;
      end else if (b == CH_PERCENT) begin
        esc_cnt_nxt   = ESC_FIRST;
        esc_high_nxt  = '0;
        esc_ok_nxt    = 1'b0;
        esc_abort_nxt = 1'b0;
      end else if (b == CH_PLUS) begin
        res[cnt[0]] = fud_data(vp_r, CH_SPACE);
        cnt = cnt + 2'd1;
      end else begin
        res[cnt[0]] = fud_data(vp_r, b);
        cnt = cnt + 2'd1;
      end
    end

    // End of data: flush a cut-short escape, then close the pair
    if (last && !done) begin
      if (esc_cnt_nxt != ESC_IDLE) begin
        v = '0;
        if (esc_cnt_nxt == ESC_SECOND && esc_ok_nxt && !esc_abort_nxt) begin
          v = {4'h0, esc_high_nxt};
        end
        res[cnt[0]] = fud_data(vp_nxt, v);
        cnt = cnt + 2'd1;
        esc_cnt_nxt   = ESC_IDLE;
        esc_high_nxt  = '0;
        esc_ok_nxt    = 1'b0;
        esc_abort_nxt = 1'b0;
      end
      res[cnt[0]] = fud_marker(vp_nxt, 1'b1);
      cnt = cnt + 2'd1;
      vp_nxt = 1'b0;
    end

    // Mark the final result of this word
    if (cnt == 2'd2) begin
      res[1].run_last = 1'b1;
    end else if (cnt == 2'd1) begin
      res[0].run_last = 1'b1;
    end

    res0    = res[0];
    res1    = res[1];
    res_cnt = cnt;
  end

  // Update decoder state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r        <= 1'b0;
      esc_cnt_r   <= ESC_IDLE;
      esc_high_r  <= '0;
      esc_ok_r    <= 1'b0;
      esc_abort_r <= 1'b0;
    end else if (in_fire) begin
      vp_r        <= vp_nxt;
      esc_cnt_r   <= esc_cnt_nxt;
      esc_high_r  <= esc_high_nxt;
      esc_ok_r    <= esc_ok_nxt;
      esc_abort_r <= esc_abort_nxt;
    end
  end

  // Push results into the queue
  always_ff @(posedge clk) begin
    if (in_fire && res_cnt != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (in_fire && res_cnt == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  // Track queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(res_cnt);
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_r + (in_fire ? CNT_W'(res_cnt) : '0) - (out_fire ? CNT_W'(1) : '0);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(RES_DEPTH))
    else $error("result queue overfilled");

  a_esc_code: assert property (@(posedge clk) disable iff (!rst_n)
    esc_cnt_r != 2'd3)
    else $error("escape counter out of range");

  a_esc_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(esc_ok_r && esc_abort_r))
    else $error("escape marked both valid and aborted");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.in_last) |=> (!vp_r && esc_cnt_r == ESC_IDLE))
    else $error("state not returned to name part after last byte");

endmodule

// File: tb/tb_form_urlencoded_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_form_urlencoded_decoder_unit
// Self-checking bench for the streaming form-encoded string decoder.
// ----------------------------------------------------------------------------
// Feeds raw bytes through the valid/ready input channel and checks every
// decoded result in order against a local decoder model. The stimulus covers
// hand-picked corner strings, then mostly well-formed name/value forms with
// random content plus random noise bytes. It runs in four idling phases,
// including a long output hold-off that backs the block up.
module tb_form_urlencoded_decoder_unit
  import fud_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 20;
  localparam int HOLD_CYCLES  = 64;
  localparam int PHASE_WORDS  = 42;
  localparam int MAX_REPORTS  = 10;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  fud_in_t  in_data = '0;
  logic     out_valid;
  logic     out_rdy = 1'b0;
  fud_out_t out_data;

  fud_in_t    pending_words[$];
  fud_out_t   expected_results[$];
  logic [7:0] form_bytes[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int error_count = 0;
  int phase_words = 0;

  // Decoder state
  logic       value_part = 1'b0;
  logic [1:0] esc_count = ESC_IDLE;
  logic [3:0] esc_high = 4'h0;
  logic       esc_high_ok = 1'b0;
  logic       esc_abort = 1'b0;

  form_urlencoded_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_rdy   (out_rdy),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  // Bit 4 flags a hex digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] t;
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      t = c - CH_DIGIT_0;
      return {1'b1, t[3:0]};
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      t = c - CH_UPPER_A + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      t = c - CH_LOWER_A + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

  task automatic emit_data(input logic [7:0] b);
    fud_out_t r;
    r = '0;
    r.kind = value_part ? KIND_VALUE : KIND_NAME;
    r.out_byte = b;
    // lowercase letters of the name only
    if (!value_part && b >= CH_UPPER_A && b <= CH_UPPER_Z) r.out_byte = b + CASE_DELTA;
    expected_results.push_back(r);
  endtask

  task automatic emit_marker(input logic hv, input logic eod);
    fud_out_t r;
    r = '0;
    r.kind = KIND_EOP;
    r.has_value = hv;
    r.end_of_data = eod;
    expected_results.push_back(r);
  endtask

  task automatic clear_escape();
    esc_count = ESC_IDLE;
    esc_high = 4'h0;
    esc_high_ok = 1'b0;
    esc_abort = 1'b0;
  endtask

  // Emit what a cut-short escape has collected so far
  task automatic flush_escape();
    if (esc_count == ESC_SECOND && esc_high_ok && !esc_abort) emit_data({4'h0, esc_high});
    else emit_data(8'h00);
    clear_escape();
  endtask

  // Work out the results of one accepted word
  task automatic decode_word(input fud_in_t w);
    logic [7:0] b;
    logic [7:0] v;
    logic [4:0] d;
    logic       handled;
    logic       delim;
    logic       pair_closed;
    int         n0;
    b = w.in_byte;
    handled = 1'b0;
    pair_closed = 1'b0;
    n0 = expected_results.size();
    delim = (b == CH_AMP) || (b == CH_EQUALS && !value_part);

    // advance an escape in progress, or cut it short on a delimiter
    if (esc_count != ESC_IDLE) begin
      if (!delim) begin
        d = hex_nibble(b);
        handled = 1'b1;
        if (esc_count == ESC_FIRST) begin
          if (d[4]) begin
            esc_high = d[3:0];
            esc_high_ok = 1'b1;
          end else begin
            esc_abort = 1'b1;
          end
          esc_count = ESC_SECOND;
        end else begin
          v = 8'h00;
          if (esc_high_ok && !esc_abort) v = d[4] ? {esc_high, d[3:0]} : {4'h0, esc_high};
          emit_data(v);
          clear_escape();
        end
      end else begin
        flush_escape();
      end
    end

    if (!handled) begin
      if (b == CH_AMP) begin
        emit_marker(value_part, w.in_last);
        value_part = 1'b0;
        pair_closed = 1'b1;
      end else if (b == CH_EQUALS && !value_part) begin
        value_part = 1'b1;
      end else if (b == CH_PERCENT) begin
        clear_escape();
        esc_count = ESC_FIRST;
      end else if (b == CH_PLUS) begin
        emit_data(CH_SPACE);
      end else begin
        emit_data(b);
      end
    end

    // close the string; a final '&' already carries the end flag
    if (w.in_last && !pair_closed) begin
      if (esc_count != ESC_IDLE) flush_escape();
      emit_marker(value_part, 1'b1);
      value_part = 1'b0;
    end

    if (expected_results.size() > n0)
      expected_results[expected_results.size() - 1].run_last = 1'b1;
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic check_result(input fud_out_t got);
    fud_out_t want;
    if (expected_results.size() == 0) begin
      report_error($sformatf({"[%0t] unexpected result: kind=%0d byte=%02h hv=%0b ",
                              "eod=%0b last=%0b"},
                             $realtime, got.kind, got.out_byte, got.has_value,
                             got.end_of_data, got.run_last));
    end else begin
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
          got.has_value !== want.has_value || got.end_of_data !== want.end_of_data ||
          got.run_last !== want.run_last)
        report_error($sformatf({"[%0t] mismatch: expected kind=%0d byte=%02h hv=%0b eod=%0b ",
                                "last=%0b, got kind=%0d byte=%02h hv=%0b eod=%0b last=%0b"},
                               $realtime, want.kind, want.out_byte, want.has_value,
                               want.end_of_data, want.run_last, got.kind, got.out_byte,
                               got.has_value, got.end_of_data, got.run_last));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------

  // Offer the next pending word once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the output at random, or hold it off for a long stretch on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rdy <= 1'b0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_rdy <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_rdy <= 1'b0;
    end else begin
      out_rdy <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on input words, check output words, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) decode_word(in_data);
      if (out_valid && out_rdy) check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_rdy)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [7:0] b, input logic last);
    fud_in_t w;
    w.in_byte = b;
    w.in_last = last;
    pending_words.push_back(w);
    phase_words++;
  endtask

  task automatic push_string(input string s, input logic ends);
    for (int i = 0; i < s.len(); i++) push_word(s[i], ends && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] hex_or_junk();
    int r;
    if ($urandom_range(7) == 0) return 8'($urandom_range(255));
    r = $urandom_range(21);
    if (r < 10) return CH_DIGIT_0 + r[7:0];
    if (r < 16) return CH_UPPER_A + r[7:0] - 8'd10;
    return CH_LOWER_A + r[7:0] - 8'd16;
  endfunction

  // Append a name or value of random content
  task automatic append_field(input logic value_side);
    int len;
    len = $urandom_range(5);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: form_bytes.push_back(CH_UPPER_A + 8'($urandom_range(25)));
        1: form_bytes.push_back(CH_LOWER_A + 8'($urandom_range(25)));
        2: form_bytes.push_back(CH_DIGIT_0 + 8'($urandom_range(9)));
        3: form_bytes.push_back(CH_PLUS);
        4, 5: begin
          form_bytes.push_back(CH_PERCENT);
          form_bytes.push_back(hex_or_junk());
          if ($urandom_range(5) != 0) form_bytes.push_back(hex_or_junk());
        end
        6: form_bytes.push_back(value_side ? CH_EQUALS : CH_LOWER_A);
        default: form_bytes.push_back(8'($urandom_range(255)));
      endcase
    end
  endtask

  // One form string of up to four pairs, last flag on its final byte
  task automatic push_form();
    int npairs;
    form_bytes.delete();
    npairs = $urandom_range(1, 4);
    for (int p = 0; p < npairs; p++) begin
      if (p > 0) form_bytes.push_back(CH_AMP);
      append_field(1'b0);
      if ($urandom_range(3) != 0) begin
        form_bytes.push_back(CH_EQUALS);
        append_field(1'b1);
      end
    end
    if ($urandom_range(4) == 0 || form_bytes.size() == 0) form_bytes.push_back(CH_AMP);
    for (int i = 0; i < form_bytes.size(); i++)
      push_word(form_bytes[i], i == form_bytes.size() - 1);
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) push_word(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  task automatic wait_drain();
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int send_pct[4];
    int recv_pct[4];
    send_pct = '{0, 85, 0, 38};
    recv_pct = '{0, 0, 85, 38};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      phase_words = 0;
      if (phase == 0) begin
        // uppercase name, '+', full, broken and half escapes, escape cut by end
        push_string("Z+%4a=%zz%4g%F", 1'b1);
        // escape cut by '&', empty pair, '=' inside a value, zero and top bytes
        push_string("%&&=x=", 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b1);
        // escape cut by '=' in the name, trailing '&' ends the data
        push_string("%4=&", 1'b1);
      end
      while (phase_words < PHASE_WORDS) begin
        if ($urandom_range(6) == 0) push_noise();
        else push_form();
      end
      // back the block up while the sender keeps offering
      if (phase == 0) hold_req++;
      wait_drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/fud_pkg.sv
design/form_urlencoded_decoder_unit.sv
tb/tb_form_urlencoded_decoder_unit.sv
